/* sv/midi_va_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI voice allocator package
// Shared types and codes for the voice allocator: sequencer states,
// decoded operations, result actions and MIDI message constants.
// ----------------------------------------------------------------------------
package midi_va_pkg;

    // Widths fixed by the item format.
    localparam int KIND_BITS   = 2;
    localparam int NOTE_BITS   = 7;
    localparam int VEL_BITS    = 7;
    localparam int SLOT_BITS   = 4;
    localparam int MASK_BITS   = 16;
    localparam int STATUS_BITS = 8;

    // Input kinds.
    localparam logic [KIND_BITS-1:0] KIND_MIDI   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_TICK   = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_RETIRE = 2'd2;

    // A message is only decoded when it carries all three bytes.
    localparam logic [1:0] FULL_MESSAGE = 2'd3;

    // MIDI status decoding; the low nibble is the channel and is ignored.
    localparam logic [STATUS_BITS-1:0] TYPE_MASK     = 8'hF0;
    localparam logic [STATUS_BITS-1:0] TYPE_NOTE_ON  = 8'h90;
    localparam logic [STATUS_BITS-1:0] TYPE_NOTE_OFF = 8'h80;

    // Result actions.
    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_ASSIGN  = 2'd1,
        ACT_RELEASE = 2'd2,
        ACT_RETIRE  = 2'd3
    } t_action;

    // Decoded operation of the beat being worked on.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_RETIRE,
        OP_NOTE_ON,
        OP_NOTE_OFF
    } t_op;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

endpackage

/* sv/midi_voice_allocator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MIDI voice allocator
// Polyphonic voice allocation with oldest-voice stealing, built around a
// per-voice note memory and age memory that a sequencer sweeps.
// ----------------------------------------------------------------------------
// The allocator takes one beat at a time. A note-on, note-off or tick beat
// sweeps every voice entry once through the note and age memories, which
// have a registered read port, then passes the drain and finish states
// before its result is registered; a retire, an ignored message or an
// unknown kind goes straight to the finish state. The sweep of the
// voice memories is what sets the length of a beat. The result sits in an output
// register, so the next input beat is taken as soon as the sequencer is
// idle again, even while the previous result has not yet been collected;
// a finished result only waits if the output register is still full.
// Active flags and written flags live in flip-flops and are cleared by
// reset, so no clearing pass is needed: a voice entry that has never been
// written reads as note 0.
// ----------------------------------------------------------------------------
module midi_voice_allocator_unit #(
    parameter int VOICES   = 16,
    parameter int AGE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [1:0]  i_byte_count,
    input  logic [7:0]  i_status_byte,
    input  logic [6:0]  i_note_number,
    input  logic [6:0]  i_note_velocity,
    input  logic [3:0]  i_finished_voice,

    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_action,
    output logic [3:0]  o_voice_slot,
    output logic        o_stolen,
    output logic [6:0]  o_out_note,
    output logic [6:0]  o_out_velocity,
    output logic [15:0] o_release_mask
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam logic [VW-1:0] LAST_VOICE = VW'(VOICES - 1);

    // ------------------------------------------------------------------
    // Voice memories: one entry per voice, read through a registered
    // read port.
    // ------------------------------------------------------------------
    logic [midi_va_pkg::NOTE_BITS-1:0] r_note_mem [VOICES];
    logic [AGE_BITS-1:0]               r_age_mem  [VOICES];
    logic [midi_va_pkg::NOTE_BITS-1:0] r_note_rd;
    logic [AGE_BITS-1:0]               r_age_rd;

    logic                              mem_re;
    logic [VW-1:0]                     mem_ra;
    logic                              mem_we;
    logic [VW-1:0]                     mem_wa;
    logic [midi_va_pkg::NOTE_BITS-1:0] mem_wnote;
    logic [AGE_BITS-1:0]               mem_wage;

    // ------------------------------------------------------------------
    // Control and working registers.
    // ------------------------------------------------------------------
    midi_va_pkg::t_state r_state, n_state;
    midi_va_pkg::t_op    r_op, n_op;
    logic [VOICES-1:0]   r_active, n_active;
    logic [VOICES-1:0]   r_written, n_written;
    logic [VW-1:0]       r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [VW-1:0]       r_pidx, n_pidx;

    // Latched beat payload.
    logic [midi_va_pkg::NOTE_BITS-1:0] r_note, n_note;
    logic [midi_va_pkg::VEL_BITS-1:0]  r_vel, n_vel;
    logic [3:0]                        r_fin, n_fin;

    // Sweep accumulators.
    logic                r_same_f, n_same_f;
    logic [VW-1:0]       r_same, n_same;
    logic                r_free_f, n_free_f;
    logic [VW-1:0]       r_free, n_free;
    logic                r_old_f, n_old_f;
    logic [VW-1:0]       r_old, n_old;
    logic [AGE_BITS-1:0] r_old_age, n_old_age;
    logic [midi_va_pkg::MASK_BITS-1:0] r_mask, n_mask;

    // Output register.
    logic                              r_out_valid, n_out_valid;
    midi_va_pkg::t_action              r_action, n_action;
    logic [midi_va_pkg::SLOT_BITS-1:0] r_slot, n_slot;
    logic                              r_stolen, n_stolen;
    logic [midi_va_pkg::NOTE_BITS-1:0] r_out_note, n_out_note;
    logic [midi_va_pkg::VEL_BITS-1:0]  r_out_vel, n_out_vel;
    logic [midi_va_pkg::MASK_BITS-1:0] r_out_mask, n_out_mask;

    // Entry under inspection and the chosen voice for a note-on.
    logic                              e_act;
    logic [midi_va_pkg::NOTE_BITS-1:0] e_note;
    logic [VW-1:0]                     w_pick;
    logic                              w_leave;
    logic [midi_va_pkg::STATUS_BITS-1:0] w_type;

    assign e_act  = r_active[r_pidx];
    // A voice never written reads as note zero.
    assign e_note = r_written[r_pidx] ? r_note_rd : '0;
    assign w_pick = r_same_f ? r_same : (r_free_f ? r_free : r_old);
    assign w_leave = (r_state == midi_va_pkg::ST_FINISH) && (!r_out_valid || i_out_ready);
    assign w_type = i_status_byte & midi_va_pkg::TYPE_MASK;

    // ------------------------------------------------------------------
    // Sequencer: next state, sweep processing and result formation.
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_active    = r_active;
        n_written   = r_written;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pidx      = r_pidx;
        n_note      = r_note;
        n_vel       = r_vel;
        n_fin       = r_fin;
        n_same_f    = r_same_f;
        n_same      = r_same;
        n_free_f    = r_free_f;
        n_free      = r_free;
        n_old_f     = r_old_f;
        n_old       = r_old;
        n_old_age   = r_old_age;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && !i_out_ready;
        n_action    = r_action;
        n_slot      = r_slot;
        n_stolen    = r_stolen;
        n_out_note  = r_out_note;
        n_out_vel   = r_out_vel;
        n_out_mask  = r_out_mask;

        mem_re    = 1'b0;
        mem_ra    = r_idx;
        mem_we    = 1'b0;
        mem_wa    = r_pidx;
        mem_wnote = r_note_rd;
        mem_wage  = r_age_rd + AGE_BITS'(1);

        // The entry read in the previous cycle is dealt with here.
        if (r_pend) begin
            unique case (r_op)
                midi_va_pkg::OP_TICK: begin
                    // Active voices age by one, saturating at all ones.
                    if (e_act && (r_age_rd != '1)) begin
                        mem_we = 1'b1;
                    end
                end
                midi_va_pkg::OP_NOTE_ON: begin
                    if (e_act && (e_note == r_note) && !r_same_f) begin
                        n_same_f = 1'b1;
                        n_same   = r_pidx;
                    end
                    if (!e_act && !r_free_f) begin
                        n_free_f = 1'b1;
                        n_free   = r_pidx;
                    end
                    if (e_act && (!r_old_f || (r_age_rd > r_old_age))) begin
                        n_old_f   = 1'b1;
                        n_old     = r_pidx;
                        n_old_age = r_age_rd;
                    end
                end
                midi_va_pkg::OP_NOTE_OFF: begin
                    // Voices beyond the sixteenth fall off the end of the shift.
                    if (e_note == r_note) begin
                        n_mask = r_mask | (midi_va_pkg::MASK_BITS'(1) << r_pidx);
                    end
                end
                default: begin
                end
            endcase
        end

        unique case (r_state)
            midi_va_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_note   = i_note_number;
                    n_vel    = i_note_velocity;
                    n_fin    = i_finished_voice;
                    n_idx    = '0;
                    n_same_f = 1'b0;
                    n_free_f = 1'b0;
                    n_old_f  = 1'b0;
                    n_mask   = '0;
                    if (i_kind == midi_va_pkg::KIND_TICK) begin
                        n_op = midi_va_pkg::OP_TICK;
                    end else if (i_kind == midi_va_pkg::KIND_RETIRE) begin
                        n_op = midi_va_pkg::OP_RETIRE;
                    end else if ((i_kind == midi_va_pkg::KIND_MIDI)
                                 && (i_byte_count == midi_va_pkg::FULL_MESSAGE)
                                 && (w_type == midi_va_pkg::TYPE_NOTE_ON)
                                 && (i_note_velocity != '0)) begin
                        n_op = midi_va_pkg::OP_NOTE_ON;
                    end else if ((i_kind == midi_va_pkg::KIND_MIDI)
                                 && (i_byte_count == midi_va_pkg::FULL_MESSAGE)
                                 && ((w_type == midi_va_pkg::TYPE_NOTE_ON)
                                     || (w_type == midi_va_pkg::TYPE_NOTE_OFF))) begin
                        n_op = midi_va_pkg::OP_NOTE_OFF;
                    end else begin
                        n_op = midi_va_pkg::OP_NONE;
                    end
                    if ((i_kind == midi_va_pkg::KIND_RETIRE) || (n_op == midi_va_pkg::OP_NONE)) begin
                        n_state = midi_va_pkg::ST_FINISH;
                    end else begin
                        n_state = midi_va_pkg::ST_SCAN;
                    end
                end
            end
            midi_va_pkg::ST_SCAN: begin
                mem_re = 1'b1;
                n_pend = 1'b1;
                n_pidx = r_idx;
                if (r_idx == LAST_VOICE) begin
                    n_state = midi_va_pkg::ST_DRAIN;
                end else begin
                    n_idx = r_idx + VW'(1);
                end
            end
            midi_va_pkg::ST_DRAIN: begin
                n_state = midi_va_pkg::ST_FINISH;
            end
            midi_va_pkg::ST_FINISH: begin
                if (w_leave) begin
                    n_state     = midi_va_pkg::ST_IDLE;
                    n_out_valid = 1'b1;
                    n_action    = midi_va_pkg::ACT_NONE;
                    n_slot      = '0;
                    n_stolen    = 1'b0;
                    n_out_note  = '0;
                    n_out_vel   = '0;
                    n_out_mask  = '0;
                    unique case (r_op)
                        midi_va_pkg::OP_RETIRE: begin
                            // Out-of-range slots are ignored; idle slots still report.
                            if (32'(r_fin) < VOICES) begin
                                n_active[VW'(r_fin)] = 1'b0;
                                n_action = midi_va_pkg::ACT_RETIRE;
                                n_slot   = r_fin;
                            end
                        end
                        midi_va_pkg::OP_NOTE_ON: begin
                            mem_we             = 1'b1;
                            mem_wa             = w_pick;
                            mem_wnote          = r_note;
                            mem_wage           = '0;
                            n_active[w_pick]   = 1'b1;
                            n_written[w_pick]  = 1'b1;
                            n_action           = midi_va_pkg::ACT_ASSIGN;
                            n_slot             = midi_va_pkg::SLOT_BITS'(w_pick);
                            n_stolen           = !r_same_f && !r_free_f;
                            n_out_note         = r_note;
                            n_out_vel          = r_vel;
                        end
                        midi_va_pkg::OP_NOTE_OFF: begin
                            n_action   = midi_va_pkg::ACT_RELEASE;
                            n_out_note = r_note;
                            n_out_mask = r_mask;
                        end
                        default: begin
                        end
                    endcase
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Voice memories.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_note_mem[mem_wa] <= mem_wnote;
            r_age_mem[mem_wa]  <= mem_wage;
        end
        if (mem_re) begin
            r_note_rd <= r_note_mem[mem_ra];
            r_age_rd  <= r_age_mem[mem_ra];
        end
    end

    // ------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= midi_va_pkg::ST_IDLE;
            r_active    <= '0;
            r_written   <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_written   <= n_written;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_idx      <= n_idx;
        r_pidx     <= n_pidx;
        r_note     <= n_note;
        r_vel      <= n_vel;
        r_fin      <= n_fin;
        r_same_f   <= n_same_f;
        r_same     <= n_same;
        r_free_f   <= n_free_f;
        r_free     <= n_free;
        r_old_f    <= n_old_f;
        r_old      <= n_old;
        r_old_age  <= n_old_age;
        r_mask     <= n_mask;
        r_action   <= n_action;
        r_slot     <= n_slot;
        r_stolen   <= n_stolen;
        r_out_note <= n_out_note;
        r_out_vel  <= n_out_vel;
        r_out_mask <= n_out_mask;
    end

    assign o_in_ready     = (r_state == midi_va_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_action       = r_action;
    assign o_voice_slot   = r_slot;
    assign o_stolen       = r_stolen;
    assign o_out_note     = r_out_note;
    assign o_out_velocity = r_out_vel;
    assign o_release_mask = r_out_mask;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A finished note-on sweep always has some candidate voice.
    a_pick_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == midi_va_pkg::ST_FINISH) && (r_op == midi_va_pkg::OP_NOTE_ON)
        |-> (r_same_f || r_free_f || r_old_f))
        else $error("note-on sweep ended without a candidate voice");

    // The assigned voice is active once the result has been issued.
    a_pick_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_leave && (r_op == midi_va_pkg::OP_NOTE_ON)
        |=> r_active[$past(w_pick)])
        else $error("assigned voice not marked active");

    // A release mask only ever accompanies a release result.
    a_mask_only_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_action != midi_va_pkg::ACT_RELEASE) |-> (o_release_mask == '0))
        else $error("release mask set on a non-release result");

    // Stealing is only reported on an assignment.
    a_stolen_assign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_stolen |-> (o_action == midi_va_pkg::ACT_ASSIGN))
        else $error("stolen flag set on a non-assignment result");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Voice allocator testbench
// Drives MIDI, tick and retire beats into the voice allocator through a
// queue-fed driver and checks every result beat against a voice pool kept
// alongside the design. The run opens with a directed sequence and then
// moves through random phases that idle the sender, stall the receiver or
// hold the receiver off for a long stretch.
// ----------------------------------------------------------------------------
module testbench;

    localparam int VOICE_COUNT  = 16;
    localparam int AGE_BITS     = 32;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int HOLD_CYCLES  = 500;
    localparam int TAIL_CYCLES  = 40;
    localparam int REPORT_LIMIT = 10;

    // The kind code that the allocator does not know.
    localparam logic [midi_va_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    // A status whose type is neither note-on nor note-off.
    localparam logic [midi_va_pkg::STATUS_BITS-1:0] TYPE_CONTROL = 8'hB0;

    // One input beat, field for field as it appears on the ports.
    typedef struct packed {
        logic [midi_va_pkg::KIND_BITS-1:0]   kind;
        logic [1:0]                          byte_count;
        logic [midi_va_pkg::STATUS_BITS-1:0] status;
        logic [midi_va_pkg::NOTE_BITS-1:0]   note;
        logic [midi_va_pkg::VEL_BITS-1:0]    vel;
        logic [midi_va_pkg::SLOT_BITS-1:0]   fin;
    } t_midi_beat;

    // One result beat.
    typedef struct packed {
        midi_va_pkg::t_action              action;
        logic [midi_va_pkg::SLOT_BITS-1:0] slot;
        logic                              stolen;
        logic [midi_va_pkg::NOTE_BITS-1:0] note;
        logic [midi_va_pkg::VEL_BITS-1:0]  vel;
        logic [midi_va_pkg::MASK_BITS-1:0] mask;
    } t_voice_event;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic       in_valid    = 1'b0;
    logic       o_in_ready;
    t_midi_beat beat_on_bus = '0;

    logic                              o_out_valid;
    logic                              out_ready  = 1'b0;
    logic                              sink_hold  = 1'b0;
    logic [1:0]                        o_action;
    logic [midi_va_pkg::SLOT_BITS-1:0] o_voice_slot;
    logic                              o_stolen;
    logic [midi_va_pkg::NOTE_BITS-1:0] o_out_note;
    logic [midi_va_pkg::VEL_BITS-1:0]  o_out_velocity;
    logic [midi_va_pkg::MASK_BITS-1:0] o_release_mask;

    // Our own copy of the voice pool, updated in the order beats are accepted.
    logic                              voice_active [VOICE_COUNT];
    logic [midi_va_pkg::NOTE_BITS-1:0] voice_note   [VOICE_COUNT];
    logic [AGE_BITS-1:0]               voice_age    [VOICE_COUNT];

    t_midi_beat   pending_beats[$];
    t_voice_event pool_events_due[$];

    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    int cycle_count     = 0;
    int hold_from       = -1;
    int bad_results     = 0;

    midi_voice_allocator_unit #(
        .VOICES   (VOICE_COUNT),
        .AGE_BITS (AGE_BITS)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_kind           (beat_on_bus.kind),
        .i_byte_count     (beat_on_bus.byte_count),
        .i_status_byte    (beat_on_bus.status),
        .i_note_number    (beat_on_bus.note),
        .i_note_velocity  (beat_on_bus.vel),
        .i_finished_voice (beat_on_bus.fin),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_action         (o_action),
        .o_voice_slot     (o_voice_slot),
        .o_stolen         (o_stolen),
        .o_out_note       (o_out_note),
        .o_out_velocity   (o_out_velocity),
        .o_release_mask   (o_release_mask)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        for (int v = 0; v < VOICE_COUNT; v++) begin
            voice_active[v] = 1'b0;
            voice_note[v]   = '0;
            voice_age[v]    = '0;
        end
    end

    // Applies one accepted beat to the voice pool and returns the result
    // beat that the allocator ought to give for it.
    function automatic t_voice_event run_voice_pool(input t_midi_beat b);
        t_voice_event                        ev;
        logic [midi_va_pkg::STATUS_BITS-1:0] msg_type;
        int                                  same_v;
        int                                  free_v;
        int                                  oldest_v;
        int                                  pick;
        ev       = '0;
        msg_type = b.status & midi_va_pkg::TYPE_MASK;
        same_v   = -1;
        free_v   = -1;
        oldest_v = -1;
        case (b.kind)
            midi_va_pkg::KIND_TICK: begin
                // Ages saturate rather than wrap.
                for (int v = 0; v < VOICE_COUNT; v++) begin
                    if (voice_active[v] && voice_age[v] != '1) begin
                        voice_age[v] = voice_age[v] + 1'b1;
                    end
                end
            end
            midi_va_pkg::KIND_RETIRE: begin
                // Retiring an idle voice still reports the retirement.
                if (b.fin < VOICE_COUNT) begin
                    voice_active[b.fin] = 1'b0;
                    ev.action = midi_va_pkg::ACT_RETIRE;
                    ev.slot   = b.fin;
                end
            end
            midi_va_pkg::KIND_MIDI: begin
                if (b.byte_count == midi_va_pkg::FULL_MESSAGE) begin
                    if (msg_type == midi_va_pkg::TYPE_NOTE_ON && b.vel != '0) begin
                        for (int v = 0; v < VOICE_COUNT; v++) begin
                            if (voice_active[v] && voice_note[v] == b.note && same_v < 0) begin
                                same_v = v;
                            end
                            if (!voice_active[v] && free_v < 0) begin
                                free_v = v;
                            end
                            // Strictly greater, so ties stay with the lowest index.
                            if (voice_active[v] &&
                                (oldest_v < 0 || voice_age[v] > voice_age[oldest_v])) begin
                                oldest_v = v;
                            end
                        end
                        if (same_v >= 0) begin
                            pick = same_v;
                        end else if (free_v >= 0) begin
                            pick = free_v;
                        end else begin
                            pick      = oldest_v;
                            ev.stolen = 1'b1;
                        end
                        voice_active[pick] = 1'b1;
                        voice_note[pick]   = b.note;
                        voice_age[pick]    = '0;
                        ev.action = midi_va_pkg::ACT_ASSIGN;
                        ev.slot   = midi_va_pkg::SLOT_BITS'(pick);
                        ev.note   = b.note;
                        ev.vel    = b.vel;
                    end else if (msg_type == midi_va_pkg::TYPE_NOTE_OFF
                                 || msg_type == midi_va_pkg::TYPE_NOTE_ON) begin
                        // Every voice holding the note counts, active or not.
                        for (int v = 0; v < VOICE_COUNT && v < midi_va_pkg::MASK_BITS;
                             v++) begin
                            if (voice_note[v] == b.note) begin
                                ev.mask[v] = 1'b1;
                            end
                        end
                        ev.action = midi_va_pkg::ACT_RELEASE;
                        ev.note   = b.note;
                    end
                end
            end
            default: begin
            end
        endcase
        return ev;
    endfunction

    // Random beat: mostly well-formed note traffic on a narrow band of
    // notes, so that repeated notes and full pools are common, with ticks,
    // retirements and a share of wholly random noise.
    function automatic t_midi_beat random_beat();
        t_midi_beat b;
        int         roll;
        b          = '0;
        roll       = $urandom_range(99);
        b.kind     = midi_va_pkg::KIND_MIDI;
        b.byte_count = midi_va_pkg::FULL_MESSAGE;
        b.note     = ($urandom_range(3) == 0)
                     ? midi_va_pkg::NOTE_BITS'($urandom_range(127))
                     : midi_va_pkg::NOTE_BITS'(20 + $urandom_range(23));
        b.vel      = midi_va_pkg::VEL_BITS'($urandom_range(127));
        b.fin      = midi_va_pkg::SLOT_BITS'($urandom_range(15));
        if (roll < 42) begin
            b.status = midi_va_pkg::TYPE_NOTE_ON
                       | midi_va_pkg::STATUS_BITS'($urandom_range(15));
            b.vel    = ($urandom_range(9) == 0)
                       ? '0 : midi_va_pkg::VEL_BITS'($urandom_range(1, 127));
        end else if (roll < 62) begin
            b.status = midi_va_pkg::TYPE_NOTE_OFF
                       | midi_va_pkg::STATUS_BITS'($urandom_range(15));
        end else if (roll < 76) begin
            b.kind = midi_va_pkg::KIND_TICK;
        end else if (roll < 86) begin
            b.kind = midi_va_pkg::KIND_RETIRE;
        end else begin
            b.kind       = midi_va_pkg::KIND_BITS'($urandom_range(3));
            b.byte_count = 2'($urandom_range(3));
            b.status     = midi_va_pkg::STATUS_BITS'($urandom_range(255));
        end
        return b;
    endfunction

    task automatic queue_beat(input logic [midi_va_pkg::KIND_BITS-1:0] kind,
                              input logic [1:0] count,
                              input logic [midi_va_pkg::STATUS_BITS-1:0] status,
                              input int note, input int vel, input int fin);
        t_midi_beat b;
        b.kind       = kind;
        b.byte_count = count;
        b.status     = status;
        b.note       = midi_va_pkg::NOTE_BITS'(note);
        b.vel        = midi_va_pkg::VEL_BITS'(vel);
        b.fin        = midi_va_pkg::SLOT_BITS'(fin);
        pending_beats.push_back(b);
    endtask

    // Waits until every queued beat has gone in and every result is back.
    task automatic drain();
        while (pending_beats.size() != 0 || in_valid || pool_events_due.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(input int beats, input int idle_pct, input int stall_pct);
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        for (int n = 0; n < beats; n++) begin
            pending_beats.push_back(random_beat());
        end
        drain();
    endtask

    // Driver: offers the next pending beat, keeping valid and the payload
    // steady until the beat is taken. Prediction happens at acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || o_in_ready) begin
            if (in_valid) begin
                pool_events_due.push_back(run_voice_pool(beat_on_bus));
            end
            if (pending_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                beat_on_bus <= pending_beats.pop_front();
                in_valid    <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction and
    // chooses the next ready level.
    always @(posedge i_clk) begin
        t_voice_event got;
        t_voice_event want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                got.action = midi_va_pkg::t_action'(o_action);
                got.slot   = o_voice_slot;
                got.stolen = o_stolen;
                got.note   = o_out_note;
                got.vel    = o_out_velocity;
                got.mask   = o_release_mask;
                if (pool_events_due.size() == 0) begin
                    bad_results <= bad_results + 1;
                    if (bad_results < REPORT_LIMIT) begin
                        $display("cycle %0d: result beat with nothing predicted, action %0d",
                                 cycle_count, got.action);
                    end
                end else begin
                    want = pool_events_due.pop_front();
                    if (got !== want) begin
                        bad_results <= bad_results + 1;
                        if (bad_results < REPORT_LIMIT) begin
                            $display("cycle %0d: want act %0d slot %0d stl %0d note %0d vel %0d mask %h",
                                     cycle_count, want.action, want.slot, want.stolen,
                                     want.note, want.vel, want.mask);
                            $display("cycle %0d: got  act %0d slot %0d stl %0d note %0d vel %0d mask %h",
                                     cycle_count, got.action, got.slot, got.stolen,
                                     got.note, got.vel, got.mask);
                        end
                    end
                end
            end
            out_ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Long receiver hold-off, timed from the cycle count in a process of its
    // own, so that the allocator fills up and refuses input.
    always @(posedge i_clk) begin
        sink_hold <= (hold_from >= 0) && (cycle_count >= hold_from)
                     && (cycle_count < hold_from + HOLD_CYCLES);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening. Messages that must be ignored come first.
        queue_beat(midi_va_pkg::KIND_MIDI, 2'd2, midi_va_pkg::TYPE_NOTE_ON,
                   60, 100, 0);                                      // short message
        queue_beat(KIND_UNUSED, midi_va_pkg::FULL_MESSAGE, midi_va_pkg::TYPE_NOTE_ON,
                   60, 100, 0);
        queue_beat(midi_va_pkg::KIND_MIDI, midi_va_pkg::FULL_MESSAGE, TYPE_CONTROL | 8'h5,
                   60, 100, 0);
        // Never-written voices all hold note 0, so this releases all of them.
        queue_beat(midi_va_pkg::KIND_MIDI, midi_va_pkg::FULL_MESSAGE,
                   midi_va_pkg::TYPE_NOTE_OFF, 0, 0, 0);
        // A note-on with zero velocity behaves as a note-off.
        queue_beat(midi_va_pkg::KIND_MIDI, midi_va_pkg::FULL_MESSAGE,
                   midi_va_pkg::TYPE_NOTE_ON | 8'hF, 127, 0, 0);
        queue_beat(midi_va_pkg::KIND_RETIRE, 2'd0, 8'h00, 0, 0, 15);  // idle voice
        queue_beat(midi_va_pkg::KIND_TICK, 2'd0, 8'h00, 0, 0, 0);     // nothing to age
        // Fill every voice, each on its own channel.
        for (int v = 0; v < VOICE_COUNT; v++) begin
            queue_beat(midi_va_pkg::KIND_MIDI, midi_va_pkg::FULL_MESSAGE,
                       midi_va_pkg::TYPE_NOTE_ON | midi_va_pkg::STATUS_BITS'(v),
                       127 - 8 * v, (v == 0) ? 127 : v, 0);
        end
        queue_beat(midi_va_pkg::KIND_TICK, 2'd0, 8'h00, 0, 0, 0);
        // All ages equal: the lowest voice is stolen, then the next oldest.
        queue_beat(midi_va_pkg::KIND_MIDI, midi_va_pkg::FULL_MESSAGE,
                   midi_va_pkg::TYPE_NOTE_ON, 0, 1, 0);
        queue_beat(midi_va_pkg::KIND_MIDI, midi_va_pkg::FULL_MESSAGE,
                   midi_va_pkg::TYPE_NOTE_ON, 64, 90, 0);
        // A note already sounding reuses its voice.
        queue_beat(midi_va_pkg::KIND_MIDI, midi_va_pkg::FULL_MESSAGE,
                   midi_va_pkg::TYPE_NOTE_ON, 111, 70, 0);
        queue_beat(midi_va_pkg::KIND_MIDI, midi_va_pkg::FULL_MESSAGE,
                   midi_va_pkg::TYPE_NOTE_OFF | 8'hC, 0, 127, 0);
        queue_beat(midi_va_pkg::KIND_RETIRE, 2'd0, 8'h00, 0, 0, 0);
        queue_beat(midi_va_pkg::KIND_MIDI, midi_va_pkg::FULL_MESSAGE,
                   midi_va_pkg::TYPE_NOTE_ON, 50, 33, 0);
        drain();

        run_phase(300, 0, 0);
        run_phase(150, 88, 0);
        run_phase(300, 0, 88);
        run_phase(300, 16, 16);

        // Receiver held off while the sender keeps offering beats.
        hold_from = cycle_count + 1;
        run_phase(150, 0, 0);

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (bad_results == 0 && pool_events_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/midi_va_pkg.sv
sv/midi_voice_allocator_unit.sv
test/testbench.sv
